[rtl/core/npt_pkg.sv]
// Shared package for the nearest point table: command and status codes, state
// machine states and the per-cell control struct. No dependencies.
`default_nettype none

package npt_pkg;

  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;   // width of point_count on the port
  localparam int unsigned PortCW  = 16;  // coordinate width on the ports
  localparam int unsigned DistW   = 33;  // distance width on the port

  typedef enum logic [KindW-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_MEMBER  = 2'd2,
    KIND_NEAREST = 2'd3
  } npt_kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK     = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_ABSENT = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_FULL   = 3'd4
  } npt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } npt_state_e;

  // control of one cell in the chain
  typedef struct packed {
    logic shift;  // take neighbour's point (list moves up one place)
    logic take;   // while shifting, take the head instead (it rejoins the tail)
    logic wr;     // write the command's point (insert at the end)
  } npt_cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/npt_cell.sv]
// One cell of the point chain: holds a single (x, z) point.
// Depends on npt_pkg for the cell control struct.
`default_nettype none

module npt_cell #(
  parameter int unsigned CW = npt_pkg::CoordBitsDef
) (
  input  wire                     clk_i,
  input  npt_pkg::npt_cell_ctl_t  ctl_i,
  input  wire  [CW-1:0]           nb_x_i,
  input  wire  [CW-1:0]           nb_z_i,
  input  wire  [CW-1:0]           head_x_i,
  input  wire  [CW-1:0]           head_z_i,
  input  wire  [CW-1:0]           wr_x_i,
  input  wire  [CW-1:0]           wr_z_i,
  output logic [CW-1:0]           x_o,
  output logic [CW-1:0]           z_o
);

  logic [CW-1:0] x_q, z_q;

  // point storage, no reset: only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      x_q <= ctl_i.take ? head_x_i : nb_x_i;
      z_q <= ctl_i.take ? head_z_i : nb_z_i;
    end else if (ctl_i.wr) begin
      x_q <= wr_x_i;
      z_q <= wr_z_i;
    end
  end

  assign x_o = x_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[rtl/core/npt_dist.sv]
// Distance unit: squared distance of each streamed point to the query and
// running minimum, first point kept on ties. Two stages. Uses no package items.
`default_nettype none

module npt_dist #(
  parameter int unsigned CW = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 feed_valid_i,
  input  wire                 feed_first_i,
  input  wire  [CW-1:0]       pt_x_i,
  input  wire  [CW-1:0]       pt_z_i,
  input  wire  [CW-1:0]       q_x_i,
  input  wire  [CW-1:0]       q_z_i,
  output logic                busy_o,
  output logic [CW-1:0]       best_x_o,
  output logic [CW-1:0]       best_z_o,
  output logic [2*CW:0]       best_d_o
);

  logic [CW-1:0]   dx, dz;
  logic [2*CW-1:0] sqx_d, sqz_d, sqx_q, sqz_q;
  logic [CW-1:0]   px_q, pz_q;
  logic            v_q, first_q;
  logic [2*CW:0]   sum;
  logic            better;
  logic [CW-1:0]   bx_q, bz_q;
  logic [2*CW:0]   bd_q;

  assign dx    = (pt_x_i >= q_x_i) ? (pt_x_i - q_x_i) : (q_x_i - pt_x_i);
  assign dz    = (pt_z_i >= q_z_i) ? (pt_z_i - q_z_i) : (q_z_i - pt_z_i);
  assign sqx_d = dx * dx;
  assign sqz_d = dz * dz;

  // stage 1: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= feed_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (feed_valid_i) begin
      sqx_q   <= sqx_d;
      sqz_q   <= sqz_d;
      px_q    <= pt_x_i;
      pz_q    <= pt_z_i;
      first_q <= feed_first_i;
    end
  end

  // stage 2: sum and strict-less compare
  assign sum    = {1'b0, sqx_q} + {1'b0, sqz_q};
  assign better = first_q || (sum < bd_q);

  always_ff @(posedge clk_i) begin
    if (v_q && better) begin
      bx_q <= px_q;
      bz_q <= pz_q;
      bd_q <= sum;
    end
  end

  assign busy_o   = v_q;
  assign best_x_o = bx_q;
  assign best_z_o = bz_q;
  assign best_d_o = bd_q;

endmodule

`default_nettype wire

[rtl/core/nearest_point_table_core.sv]
// Nearest point table: one command in flight; a new command is taken only
// once the previous one is finished. Each command runs a walk that rotates
// the whole list once through the head cell, and its finish waits while a
// held result beat is stalled. Reset clears the count and control state at
// once; point cells are not cleared and need no clearing pass.
`default_nettype none

module nearest_point_table_core #(
  parameter int unsigned CAPACITY   = npt_pkg::CapacityDef,
  parameter int unsigned COORD_BITS = npt_pkg::CoordBitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // command channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [npt_pkg::KindW-1:0]      kind_i,
  input  wire  [npt_pkg::PortCW-1:0]     px_i,
  input  wire  [npt_pkg::PortCW-1:0]     pz_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [npt_pkg::StatusW-1:0]    status_o,
  output logic                           present_o,
  output logic [npt_pkg::PortCW-1:0]     near_x_o,
  output logic [npt_pkg::PortCW-1:0]     near_z_o,
  output logic [npt_pkg::DistW-1:0]      distance_squared_o,
  output logic [npt_pkg::CountW-1:0]     point_count_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = npt_pkg::PortCW;

  // ---------------------------------------------------------------------------
  // Command capture. Coordinates are reduced to COORD_BITS.
  // ---------------------------------------------------------------------------
  logic                 in_accept;
  logic [CW+PW-1:0]     px_ext, pz_ext;
  npt_pkg::npt_kind_e   kind_q;
  logic [CW-1:0]        qx_q, qz_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign px_ext    = {{CW{1'b0}}, px_i};
  assign pz_ext    = {{CW{1'b0}}, pz_i};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= npt_pkg::npt_kind_e'(kind_i);
      qx_q   <= px_ext[CW-1:0];
      qz_q   <= pz_ext[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // count_q : points stored
  // k_q     : walk steps left (starts at count, one head pop per step)
  // sz_q    : live list length during the walk, one less once a point drops out
  // ---------------------------------------------------------------------------
  npt_pkg::npt_state_e state_q, state_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic [CNTW-1:0]     k_q, k_d;
  logic [CNTW-1:0]     sz_q, sz_d;
  logic                found_q, found_d;

  // ---------------------------------------------------------------------------
  // Chain of cells. Cell 0 is the head of the list. Every walk step pops the
  // head, all cells move up one place and the head rejoins at the tail (cell
  // sz-1), unless it is the point being removed. After count steps the list is
  // back in its original order, minus any removed point.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]           cell_x [CAPACITY];
  logic [CW-1:0]           cell_z [CAPACITY];
  npt_pkg::npt_cell_ctl_t  cell_ctl [CAPACITY];

  logic [CW-1:0] head_x, head_z;
  logic          walking, head_match, drop, push;
  logic          fin_go, ins_ok;

  assign head_x     = cell_x[0];
  assign head_z     = cell_z[0];
  assign walking    = (state_q == npt_pkg::S_WALK) && (k_q != '0);
  assign head_match = (head_x == qx_q) && (head_z == qz_q);
  assign drop       = walking && (kind_q == npt_pkg::KIND_REMOVE) && head_match && !found_q;
  assign push       = walking && !drop;
  assign ins_ok     = (kind_q == npt_pkg::KIND_INSERT) && !found_q &&
                      (count_q < CNTW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CW-1:0] nb_x, nb_z;

    if (i == CAPACITY - 1) begin : g_last
      assign nb_x = head_x;
      assign nb_z = head_z;
    end else begin : g_mid
      assign nb_x = cell_x[i+1];
      assign nb_z = cell_z[i+1];
    end

    assign cell_ctl[i].shift = walking;
    assign cell_ctl[i].take  = push && (sz_q == CNTW'(i + 1));
    assign cell_ctl[i].wr    = fin_go && ins_ok && (count_q == CNTW'(i));

    npt_cell #(
      .CW (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (cell_ctl[i]),
      .nb_x_i   (nb_x),
      .nb_z_i   (nb_z),
      .head_x_i (head_x),
      .head_z_i (head_z),
      .wr_x_i   (qx_q),
      .wr_z_i   (qz_q),
      .x_o      (cell_x[i]),
      .z_o      (cell_z[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Distance unit fed by the head during the walk
  // ---------------------------------------------------------------------------
  logic            dist_busy;
  logic [CW-1:0]   best_x, best_z;
  logic [2*CW:0]   best_d;

  npt_dist #(
    .CW (CW)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .feed_valid_i (walking),
    .feed_first_i (k_q == count_q),
    .pt_x_i       (head_x),
    .pt_z_i       (head_z),
    .q_x_i        (qx_q),
    .q_z_i        (qz_q),
    .busy_o       (dist_busy),
    .best_x_o     (best_x),
    .best_z_o     (best_z),
    .best_d_o     (best_d)
  );

  // ---------------------------------------------------------------------------
  // Result register: holds a finished beat while the next command walks
  // ---------------------------------------------------------------------------
  logic                          out_valid_q, out_valid_d;
  logic [npt_pkg::StatusW-1:0]   status_q, status_d;
  logic                          present_q, present_d;
  logic [CW-1:0]                 nx_q, nx_d, nz_q, nz_d;
  logic [2*CW:0]                 dist_q, dist_d;
  logic [CNTW-1:0]               pcnt_q;

  // ---------------------------------------------------------------------------
  // State machine: next state and result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    sz_d      = sz_q;
    found_d   = found_q;
    count_d   = count_q;
    fin_go    = 1'b0;
    status_d  = npt_pkg::STAT_OK;
    present_d = 1'b0;
    nx_d      = '0;
    nz_d      = '0;
    dist_d    = '0;

    unique case (state_q)
      npt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = npt_pkg::S_WALK;
          k_d     = count_q;
          sz_d    = count_q;
          found_d = 1'b0;
        end
      end
      npt_pkg::S_WALK: begin
        if (k_q == '0) begin
          state_d = npt_pkg::S_DRAIN;
        end else begin
          k_d = k_q - CNTW'(1);
          if (head_match) found_d = 1'b1;
          if (drop) sz_d = sz_q - CNTW'(1);
        end
      end
      npt_pkg::S_DRAIN: begin
        // wait for the last distance to reach the minimum register
        if (!dist_busy) state_d = npt_pkg::S_FINISH;
      end
      npt_pkg::S_FINISH: begin
        if (!(out_valid_q && out_stall_i)) begin
          fin_go  = 1'b1;
          state_d = npt_pkg::S_IDLE;
          count_d = sz_q + (ins_ok ? CNTW'(1) : CNTW'(0));
        end
      end
      default: state_d = npt_pkg::S_IDLE;
    endcase

    unique case (kind_q)
      npt_pkg::KIND_INSERT: begin
        if (found_q) begin
          status_d = npt_pkg::STAT_DUP;
        end else if (!ins_ok) begin
          status_d = npt_pkg::STAT_FULL;
        end
      end
      npt_pkg::KIND_REMOVE: begin
        if (!found_q) status_d = npt_pkg::STAT_ABSENT;
      end
      npt_pkg::KIND_MEMBER: begin
        present_d = found_q;
      end
      npt_pkg::KIND_NEAREST: begin
        if (count_q == '0) begin
          status_d = npt_pkg::STAT_EMPTY;
        end else begin
          nx_d   = best_x;
          nz_d   = best_z;
          dist_d = best_d;
        end
      end
      default: status_d = npt_pkg::STAT_OK;
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || fin_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npt_pkg::S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      sz_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      sz_q        <= sz_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      status_q  <= status_d;
      present_q <= present_d;
      nx_q      <= nx_d;
      nz_q      <= nz_d;
      dist_q    <= dist_d;
      pcnt_q    <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ports; values are zero-extended or cut to the port widths
  // ---------------------------------------------------------------------------
  logic [CW+PW-1:0]                   nx_ext, nz_ext;
  logic [2*CW+npt_pkg::DistW:0]       d_ext;
  logic [CNTW+npt_pkg::CountW-1:0]    pc_ext;

  assign nx_ext = {{PW{1'b0}}, nx_q};
  assign nz_ext = {{PW{1'b0}}, nz_q};
  assign d_ext  = {{npt_pkg::DistW{1'b0}}, dist_q};
  assign pc_ext = {{npt_pkg::CountW{1'b0}}, pcnt_q};

  assign in_stall_o         = (state_q != npt_pkg::S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign present_o          = present_q;
  assign near_x_o           = nx_ext[PW-1:0];
  assign near_z_o           = nz_ext[PW-1:0];
  assign distance_squared_o = d_ext[npt_pkg::DistW-1:0];
  assign point_count_o      = pc_ext[npt_pkg::CountW-1:0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("stored count above capacity");

  a_live_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != npt_pkg::S_IDLE) |-> (sz_q <= count_q))
    else $error("live list length grew during walk");

  a_beat_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == npt_pkg::S_FINISH))
    else $error("result beat raised outside finish");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == npt_pkg::STAT_EMPTY)) |-> (count_q == '0))
    else $error("empty status with points stored");

endmodule

`default_nettype wire

[verif/nearest_point_table_core_tb.sv]
// Self-checking bench for nearest_point_table_core: a directed table followed by
// fill/drain sweeps of random commands, checked against hand-written answers or
// an in-bench model of the point list. Depends on npt_pkg and the core RTL only.
`timescale 1ns / 100ps

module nearest_point_table_core_tb;

  localparam int CAP              = npt_pkg::CapacityDef;
  localparam int PW               = npt_pkg::PortCW;
  localparam int RANDOM_PER_PHASE = 457;
  localparam int DRAIN_CYCLES     = CAP + 8;     // longest walk plus margin
  localparam int CYCLE_LIMIT      = 1_000_000;

  // one result beat as the core presents it
  typedef struct packed {
    npt_pkg::npt_status_e           status;
    logic                           present;
    logic [npt_pkg::PortCW-1:0]     nx;
    logic [npt_pkg::PortCW-1:0]     nz;
    logic [npt_pkg::DistW-1:0]      dsq;
    logic [npt_pkg::CountW-1:0]     count;
  } result_t;

  typedef struct {
    npt_pkg::npt_kind_e             kind;
    logic [npt_pkg::PortCW-1:0]     x;
    logic [npt_pkg::PortCW-1:0]     z;
    bit                             typed;  // res holds a hand-written answer
    result_t                        res;
  } cmd_row_t;

  localparam result_t NO_RES = '0;

  // hand-written answers: empty table, absent point, inserts, membership,
  // far corner at largest distance, duplicate; the rest from the point model
  cmd_row_t directed_rows [24] = '{
    '{npt_pkg::KIND_NEAREST, 16'd5, 16'd5, 1'b1,
      '{npt_pkg::STAT_EMPTY, 1'b0, 16'd0, 16'd0, 33'd0, 7'd0}},
    '{npt_pkg::KIND_REMOVE, 16'd1, 16'd2, 1'b1,
      '{npt_pkg::STAT_ABSENT, 1'b0, 16'd0, 16'd0, 33'd0, 7'd0}},
    '{npt_pkg::KIND_MEMBER, 16'd0, 16'd0, 1'b1,
      '{npt_pkg::STAT_OK, 1'b0, 16'd0, 16'd0, 33'd0, 7'd0}},
    '{npt_pkg::KIND_INSERT, 16'd0, 16'd0, 1'b1,
      '{npt_pkg::STAT_OK, 1'b0, 16'd0, 16'd0, 33'd0, 7'd1}},
    '{npt_pkg::KIND_INSERT, 16'd0, 16'd0, 1'b1,
      '{npt_pkg::STAT_DUP, 1'b0, 16'd0, 16'd0, 33'd0, 7'd1}},
    '{npt_pkg::KIND_NEAREST, 16'hFFFF, 16'hFFFF, 1'b1,
      '{npt_pkg::STAT_OK, 1'b0, 16'd0, 16'd0, 33'd8589672450, 7'd1}},
    '{npt_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, 1'b1,
      '{npt_pkg::STAT_OK, 1'b0, 16'd0, 16'd0, 33'd0, 7'd2}},
    '{npt_pkg::KIND_MEMBER, 16'hFFFF, 16'hFFFF, 1'b1,
      '{npt_pkg::STAT_OK, 1'b1, 16'd0, 16'd0, 33'd0, 7'd2}},
    '{npt_pkg::KIND_NEAREST, 16'd0, 16'd0, 1'b1,
      '{npt_pkg::STAT_OK, 1'b0, 16'd0, 16'd0, 33'd0, 7'd2}},
    '{npt_pkg::KIND_NEAREST, 16'h7FFF,   16'h7FFF,   1'b0, NO_RES},
    '{npt_pkg::KIND_NEAREST, 16'h8000,   16'h8000,   1'b0, NO_RES},
    '{npt_pkg::KIND_INSERT,  16'd2,      16'd0,      1'b0, NO_RES},
    '{npt_pkg::KIND_INSERT,  16'd0,      16'd2,      1'b0, NO_RES},
    '{npt_pkg::KIND_NEAREST, 16'd1,      16'd1,      1'b0, NO_RES},  // tie: first in list wins
    '{npt_pkg::KIND_REMOVE,  16'd0,      16'd0,      1'b0, NO_RES},  // head removal, closes up
    '{npt_pkg::KIND_NEAREST, 16'd1,      16'd1,      1'b0, NO_RES},
    '{npt_pkg::KIND_MEMBER,  16'd0,      16'd0,      1'b0, NO_RES},
    '{npt_pkg::KIND_REMOVE,  16'hFFFF,   16'hFFFF,   1'b0, NO_RES},
    '{npt_pkg::KIND_INSERT,  16'hFFFF,   16'd0,      1'b0, NO_RES},
    '{npt_pkg::KIND_NEAREST, 16'd0,      16'hFFFF,   1'b0, NO_RES},
    '{npt_pkg::KIND_INSERT,  16'd0,      16'hFFFF,   1'b0, NO_RES},
    '{npt_pkg::KIND_NEAREST, 16'h8000,   16'hFFFF,   1'b0, NO_RES},
    '{npt_pkg::KIND_REMOVE,  16'd0,      16'd2,      1'b0, NO_RES},  // middle removal
    '{npt_pkg::KIND_REMOVE,  16'd0,      16'd2,      1'b0, NO_RES}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [npt_pkg::KindW-1:0]       kind_i;
  logic [npt_pkg::PortCW-1:0]      px_i;
  logic [npt_pkg::PortCW-1:0]      pz_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [npt_pkg::StatusW-1:0]     status_o;
  logic                            present_o;
  logic [npt_pkg::PortCW-1:0]      near_x_o;
  logic [npt_pkg::PortCW-1:0]      near_z_o;
  logic [npt_pkg::DistW-1:0]       distance_squared_o;
  logic [npt_pkg::CountW-1:0]      point_count_o;

  // model of the point list
  logic [npt_pkg::PortCW-1:0] pt_x [CAP];
  logic [npt_pkg::PortCW-1:0] pt_z [CAP];
  int                         pt_n;

  result_t result_q [$];
  int      send_idle_pct;
  int      recv_stall_pct;
  int      fault_cnt;
  int      cmd_cnt;
  int      beat_cnt;
  int      status_seen [5];
  int      cycle_cnt;

  nearest_point_table_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .px_i               (px_i),
    .pz_i               (pz_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .present_o          (present_o),
    .near_x_o           (near_x_o),
    .near_z_o           (near_z_o),
    .distance_squared_o (distance_squared_o),
    .point_count_o      (point_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // index of (x, z) in the list, or pt_n when it is not stored
  function automatic int point_index(input logic [npt_pkg::PortCW-1:0] x,
                                     input logic [npt_pkg::PortCW-1:0] z);
    for (int i = 0; i < pt_n; i++)
      if (pt_x[i] == x && pt_z[i] == z) return i;
    return pt_n;
  endfunction

  // applies one command to the list model and returns the beat it yields
  function automatic result_t table_apply(input npt_pkg::npt_kind_e kind,
                                          input logic [npt_pkg::PortCW-1:0] x,
                                          input logic [npt_pkg::PortCW-1:0] z);
    result_t         res;
    int              idx;
    longint unsigned dx, dz, d, best;
    res = '0;
    res.status = npt_pkg::STAT_OK;
    idx = point_index(x, z);
    case (kind)
      npt_pkg::KIND_INSERT: begin
        if (idx < pt_n) res.status = npt_pkg::STAT_DUP;
        else if (pt_n >= CAP) res.status = npt_pkg::STAT_FULL;
        else begin
          pt_x[pt_n] = x;
          pt_z[pt_n] = z;
          pt_n++;
        end
      end
      npt_pkg::KIND_REMOVE: begin
        if (idx >= pt_n) res.status = npt_pkg::STAT_ABSENT;
        else begin
          for (int i = idx; i + 1 < pt_n; i++) begin
            pt_x[i] = pt_x[i+1];
            pt_z[i] = pt_z[i+1];
          end
          pt_n--;
        end
      end
      npt_pkg::KIND_MEMBER: res.present = (idx < pt_n);
      default: begin
        if (pt_n == 0) res.status = npt_pkg::STAT_EMPTY;
        else begin
          best = 0;
          for (int i = 0; i < pt_n; i++) begin
            dx = (pt_x[i] >= x) ? longint'(pt_x[i]) - longint'(x) : longint'(x) - longint'(pt_x[i]);
            dz = (pt_z[i] >= z) ? longint'(pt_z[i]) - longint'(z) : longint'(z) - longint'(pt_z[i]);
            d  = dx * dx + dz * dz;
            // strictly closer only, so the earliest entry keeps a tie
            if (i == 0 || d < best) begin
              best   = d;
              res.nx = pt_x[i];
              res.nz = pt_z[i];
            end
          end
          res.dsq = best[npt_pkg::DistW-1:0];
        end
      end
    endcase
    res.count = pt_n[npt_pkg::CountW-1:0];
    return res;
  endfunction

  // one coordinate pair: a stored point, a tight cluster (ties and
  // duplicates), the corners and midpoints, or anything at all
  function automatic logic [2*npt_pkg::PortCW-1:0] pick_point(input int stored_pct);
    logic [npt_pkg::PortCW-1:0] x, z;
    int                         roll;
    roll = $urandom_range(99);
    if (pt_n > 0 && roll < stored_pct) begin
      roll = $urandom_range(pt_n - 1);
      return {pt_x[roll], pt_z[roll]};
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      x = PW'($urandom_range(15));
      z = PW'($urandom_range(15));
    end else if (roll < 75) begin
      x = PW'($urandom_range(1) ? 16'hFFFF : 16'h0000) ^ PW'($urandom_range(1) << 15);
      z = PW'($urandom_range(1) ? 16'hFFFF : 16'h0000) ^ PW'($urandom_range(1) << 15);
    end else begin
      x = PW'($urandom());
      z = PW'($urandom());
    end
    return {x, z};
  endfunction

  // presents one command beat and waits for it to be taken; valid is left
  // high so back-to-back beats need no second assignment in one step
  task automatic drive_cmd(input npt_pkg::npt_kind_e kind,
                           input logic [npt_pkg::PortCW-1:0] x,
                           input logic [npt_pkg::PortCW-1:0] z,
                           input bit typed, input result_t typed_res);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    px_i       <= x;
    pz_i       <= z;
    // stall is settled by the falling edge and holds until the next rise
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    res = table_apply(kind, x, z);
    result_q = {result_q, (typed ? typed_res : res)};
    cmd_cnt++;
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // a beat seen at the falling edge with stall low is taken at the next rise
  always @(negedge clk_i) begin
    result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status  = npt_pkg::npt_status_e'(status_o);
      got.present = present_o;
      got.nx      = near_x_o;
      got.nz      = near_z_o;
      got.dsq     = distance_squared_o;
      got.count   = point_count_o;
      beat_cnt++;
      if (status_o < 5) status_seen[status_o]++;
      if (result_q.size() == 0) begin
        if (fault_cnt < 10) $display("unexpected result beat, status %0d", status_o);
        fault_cnt++;
      end else begin
        exp = result_q.pop_front();
        if (got.status !== exp.status || got.present !== exp.present || got.nx !== exp.nx ||
            got.nz !== exp.nz || got.dsq !== exp.dsq || got.count !== exp.count) begin
          if (fault_cnt < 10)
            $display("beat %0d mismatch: exp st=%0d pr=%0d x=%h z=%h d=%0d n=%0d, ",
                     beat_cnt, exp.status, exp.present, exp.nx, exp.nz, exp.dsq, exp.count,
                     "got st=%0d pr=%0d x=%h z=%h d=%0d n=%0d",
                     got.status, got.present, got.nx, got.nz, got.dsq, got.count);
          fault_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, result_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    npt_pkg::npt_kind_e            kind;
    logic [npt_pkg::PortCW-1:0]    x, z;
    logic [2*npt_pkg::PortCW-1:0]  pt;
    bit                            filling;
    int                            roll;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = npt_pkg::KIND_INSERT;
    px_i           = '0;
    pz_i           = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fault_cnt      = 0;
    cmd_cnt        = 0;
    beat_cnt       = 0;
    cycle_cnt      = 0;
    pt_n           = 0;
    filling        = 1'b1;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phases: no idling, sender idle, receiver stalling, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 18 : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 18 : 0;
      if (phase == 0)
        foreach (directed_rows[r])
          drive_cmd(directed_rows[r].kind, directed_rows[r].x, directed_rows[r].z,
                    directed_rows[r].typed, directed_rows[r].res);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // sweep the table between empty and full so both ends get exercised
        if (pt_n == CAP && $urandom_range(3) == 0) filling = 1'b0;
        if (pt_n == 0) filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
          kind = (roll < 55) ? npt_pkg::KIND_INSERT : (roll < 65) ? npt_pkg::KIND_REMOVE :
                 (roll < 80) ? npt_pkg::KIND_MEMBER : npt_pkg::KIND_NEAREST;
        else
          kind = (roll < 12) ? npt_pkg::KIND_INSERT : (roll < 62) ? npt_pkg::KIND_REMOVE :
                 (roll < 80) ? npt_pkg::KIND_MEMBER : npt_pkg::KIND_NEAREST;
        case (kind)
          npt_pkg::KIND_INSERT:  pt = pick_point(35);
          npt_pkg::KIND_REMOVE:  pt = pick_point(70);
          npt_pkg::KIND_MEMBER:  pt = pick_point(50);
          default:               pt = pick_point(15);
        endcase
        {x, z} = pt;
        drive_cmd(kind, x, z, 1'b0, NO_RES);
      end
    end
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands, %0d result beats over four pacing phases, %0d cycles",
             cmd_cnt, beat_cnt, cycle_cnt);
    $display("status counts ok/dup/absent/empty/full: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
             status_seen[npt_pkg::STAT_OK], status_seen[npt_pkg::STAT_DUP],
             status_seen[npt_pkg::STAT_ABSENT], status_seen[npt_pkg::STAT_EMPTY],
             status_seen[npt_pkg::STAT_FULL], fault_cnt);
    if (fault_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[nearest_point_table_core.f]
rtl/core/npt_pkg.sv
rtl/core/npt_cell.sv
rtl/core/npt_dist.sv
rtl/core/nearest_point_table_core.sv
verif/nearest_point_table_core_tb.sv
